/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/imu_rvc_pkg.sv */
package imu_rvc_pkg;

  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam int PAYLOAD_LEN = 16;
  localparam int IDX_W = $clog2(PAYLOAD_LEN);
  localparam int CNT_W = IDX_W + 1;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_DATA  = 2'd2,
    PH_CSUM  = 2'd3
  } phase_t;

  typedef struct packed {
    logic               checksum_ok;
    logic signed [15:0] accel_z_mg;
    logic signed [15:0] accel_y_mg;
    logic signed [15:0] accel_x_mg;
    logic signed [15:0] roll_centideg;
    logic signed [15:0] pitch_centideg;
    logic signed [15:0] yaw_centideg;
    logic [7:0]         frame_index;
  } result_t;

endpackage

/* sv/imu_rvc_parser.sv */
`include "assert_macros.svh"

module imu_rvc_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  logic [7:0]             rx_byte,
  output logic                   res_valid,
  output imu_rvc_pkg::result_t   res
);

  imu_rvc_pkg::phase_t           phase;
  imu_rvc_pkg::phase_t           phase_next;
  logic [imu_rvc_pkg::CNT_W-1:0] count;
  logic [imu_rvc_pkg::CNT_W-1:0] count_next;
  logic [7:0]                    running_sum;
  logic [7:0]                    running_sum_next;
  logic [7:0]                    store [imu_rvc_pkg::PAYLOAD_LEN];
  logic                          sum_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= imu_rvc_pkg::PH_HUNT1;
      count       <= '0;
      running_sum <= '0;
    end else if (byte_valid) begin
      phase       <= phase_next;
      count       <= count_next;
      running_sum <= running_sum_next;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk) begin
    if (byte_valid && phase == imu_rvc_pkg::PH_DATA) begin
      store[count[imu_rvc_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

  always_comb begin
    phase_next       = phase;
    count_next       = count;
    running_sum_next = running_sum;
    case (phase)
      imu_rvc_pkg::PH_HUNT1: begin
        if (rx_byte == imu_rvc_pkg::HDR_BYTE) phase_next = imu_rvc_pkg::PH_HUNT2;
      end
      imu_rvc_pkg::PH_HUNT2: begin
        if (rx_byte == imu_rvc_pkg::HDR_BYTE) begin
          phase_next       = imu_rvc_pkg::PH_DATA;
          count_next       = '0;
          running_sum_next = '0;
        end else begin
          phase_next = imu_rvc_pkg::PH_HUNT1;
        end
      end
      imu_rvc_pkg::PH_DATA: begin
        running_sum_next = running_sum + rx_byte;
        count_next       = count + 1'b1;
        if (count_next == imu_rvc_pkg::CNT_W'(imu_rvc_pkg::PAYLOAD_LEN)) begin
          phase_next = imu_rvc_pkg::PH_CSUM;
        end
      end
      imu_rvc_pkg::PH_CSUM: begin
        phase_next       = imu_rvc_pkg::PH_HUNT1;
        count_next       = '0;
        running_sum_next = '0;
      end
      default: begin
        phase_next = imu_rvc_pkg::PH_HUNT1;
      end
    endcase
  end

  assign sum_match = (running_sum == rx_byte);
  assign res_valid = byte_valid && (phase == imu_rvc_pkg::PH_CSUM);

  // fields are zero on a checksum mismatch
  always_comb begin
    res = '0;
    if (sum_match) begin
      res.frame_index    = store[0];
      res.yaw_centideg   = {store[2], store[1]};
      res.pitch_centideg = {store[4], store[3]};
      res.roll_centideg  = {store[6], store[5]};
      res.accel_x_mg     = {store[8], store[7]};
      res.accel_y_mg     = {store[10], store[9]};
      res.accel_z_mg     = {store[12], store[11]};
      res.checksum_ok    = 1'b1;
    end
  end

  `ASSERT_IMPL(csum_after_full_payload, clk, rst, phase == imu_rvc_pkg::PH_CSUM,
    count == imu_rvc_pkg::CNT_W'(imu_rvc_pkg::PAYLOAD_LEN))
  `ASSERT_IMPL(data_count_in_range, clk, rst, phase == imu_rvc_pkg::PH_DATA,
    count < imu_rvc_pkg::CNT_W'(imu_rvc_pkg::PAYLOAD_LEN))

endmodule

/* sv/imu_rvc_out_buf.sv */
`include "assert_macros.svh"

module imu_rvc_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  imu_rvc_pkg::result_t in_data,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output imu_rvc_pkg::result_t out_data
);

  logic                 main_valid;
  imu_rvc_pkg::result_t main_data;
  logic                 sk_valid;
  imu_rvc_pkg::result_t sk_data;
  logic                 main_free;

  assign main_free = !main_valid || out_ready;
  assign in_ready  = !sk_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      sk_valid   <= 1'b0;
    end else if (main_free) begin
      if (sk_valid) begin
        main_valid <= 1'b1;
        sk_valid   <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid && !sk_valid) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= sk_valid ? sk_data : in_data;
    end
    if (!main_free && !sk_valid) begin
      sk_data <= in_data;
    end
  end

  `ASSERT_IMPL(skid_implies_main, clk, rst, sk_valid, main_valid)
  `ASSERT_NEXT(skid_held_on_stall, clk, rst, sk_valid && !out_ready, sk_valid)

endmodule

/* sv/imu_rvc_frame_parser_unit.sv */
// imu report frame parser
// s_* channel: one received serial byte per transaction, s_tdata[7:0] = rx_byte.
// frames are two 0xaa header bytes, 16 payload bytes and a checksum byte; a
// bad second header byte sends the parser back to hunting.
// m_* channel: one transaction per frame, issued on its checksum byte.
// m_tdata from bit 0 up: frame_index, yaw, pitch, roll, accel x, y, z
// (16-bit signed words); m_tuser = checksum_ok. on a mismatch all data
// fields are zero.
// throughput: one byte per cycle while s_tready is high; every byte is handled
// by a single pass of the parser state update.
// the result of a frame is registered into the output buffer when its checksum byte is taken.
// a two-entry output buffer (result register plus skid) keeps s_tready high
// while a result waits; s_tready drops only when both entries are full.
// reset clears the parser to hunting and empties the output buffer; payload
// storage is rewritten by every frame and has no reset.
module imu_rvc_frame_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // frame_index, yaw, pitch, roll, accel_x, accel_y, accel_z
  output logic         m_tuser    // checksum_ok
);

  logic                 byte_valid;
  logic                 res_valid;
  imu_rvc_pkg::result_t res;
  imu_rvc_pkg::result_t out_res;

  assign byte_valid = s_tvalid && s_tready;

  imu_rvc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .rx_byte    (s_tdata),
    .res_valid  (res_valid),
    .res        (res)
  );

  imu_rvc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.accel_z_mg, out_res.accel_y_mg, out_res.accel_x_mg,
                    out_res.roll_centideg, out_res.pitch_centideg,
                    out_res.yaw_centideg, out_res.frame_index};
  assign m_tuser = out_res.checksum_ok;

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_FRAME_BYTES = 650;
  localparam int IDLE_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_EVERY4,
    RDY_LONG_STALL
  } rdy_mode_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;    // rx_byte
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;    // frame_index, yaw, pitch, roll, accel_x, accel_y, accel_z
  logic         m_tuser;    // checksum_ok

  logic [7:0]           rx_bytes_q[$];
  imu_rvc_pkg::result_t pending_reports[$];
  logic                 byte_taken;
  int                   err_count;
  int                   idle_cycles;
  int                   burst_left;
  int                   gap_left;
  int                   mode_left;
  int                   stall_left;
  int                   rdy_cycle;
  rdy_mode_t            ready_mode;

  // parser mirror
  imu_rvc_pkg::phase_t           rx_phase;
  logic [imu_rvc_pkg::CNT_W-1:0] rx_count;
  logic [7:0]                    rx_sum;
  logic [7:0]                    rx_store[imu_rvc_pkg::PAYLOAD_LEN];

  imu_rvc_frame_parser_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic parse_rx_byte(input logic [7:0] b);
    imu_rvc_pkg::result_t r;
    r = '0;
    case (rx_phase)
      imu_rvc_pkg::PH_HUNT1: begin
        if (b == imu_rvc_pkg::HDR_BYTE) rx_phase = imu_rvc_pkg::PH_HUNT2;
      end
      imu_rvc_pkg::PH_HUNT2: begin
        if (b == imu_rvc_pkg::HDR_BYTE) begin
          rx_phase = imu_rvc_pkg::PH_DATA;
          rx_count = '0;
          rx_sum = '0;
        end else begin
          rx_phase = imu_rvc_pkg::PH_HUNT1;
        end
      end
      imu_rvc_pkg::PH_DATA: begin
        rx_store[rx_count[imu_rvc_pkg::IDX_W-1:0]] = b;
        rx_sum = rx_sum + b;
        rx_count = rx_count + 1'b1;
        if (rx_count >= imu_rvc_pkg::PAYLOAD_LEN) rx_phase = imu_rvc_pkg::PH_CSUM;
      end
      default: begin
        if (rx_sum == b) begin
          r.frame_index    = rx_store[0];
          r.yaw_centideg   = {rx_store[2], rx_store[1]};
          r.pitch_centideg = {rx_store[4], rx_store[3]};
          r.roll_centideg  = {rx_store[6], rx_store[5]};
          r.accel_x_mg     = {rx_store[8], rx_store[7]};
          r.accel_y_mg     = {rx_store[10], rx_store[9]};
          r.accel_z_mg     = {rx_store[12], rx_store[11]};
          r.checksum_ok    = 1'b1;
        end
        pending_reports.push_back(r);
        rx_phase = imu_rvc_pkg::PH_HUNT1;
        rx_count = '0;
        rx_sum = '0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      err_count++;
    end
  endtask

  // payload byte i sits at bits [8*i +: 8]
  task automatic push_frame(input logic [127:0] payload, input bit good_sum);
    logic [7:0] sum;
    sum = '0;
    rx_bytes_q.push_back(imu_rvc_pkg::HDR_BYTE);
    rx_bytes_q.push_back(imu_rvc_pkg::HDR_BYTE);
    for (int i = 0; i < imu_rvc_pkg::PAYLOAD_LEN; i++) begin
      rx_bytes_q.push_back(payload[8*i +: 8]);
      sum = sum + payload[8*i +: 8];
    end
    if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
    rx_bytes_q.push_back(sum);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      4: return imu_rvc_pkg::HDR_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] non_hdr_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= imu_rvc_pkg::HDR_BYTE) b = b + 1'b1;
    return b;
  endfunction

  // monitor, checker and watchdog
  always @(posedge clk) begin
    imu_rvc_pkg::result_t got;
    imu_rvc_pkg::result_t want;
    if (rst) begin
      idle_cycles <= 0;
      byte_taken <= 1'b0;
    end else begin
      got = imu_rvc_pkg::result_t'({m_tuser, m_tdata});
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          $error("report transaction with nothing expected");
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("frame_index", 16'(want.frame_index), 16'(got.frame_index));
          check_field("yaw_centideg", want.yaw_centideg, got.yaw_centideg);
          check_field("pitch_centideg", want.pitch_centideg, got.pitch_centideg);
          check_field("roll_centideg", want.roll_centideg, got.roll_centideg);
          check_field("accel_x_mg", want.accel_x_mg, got.accel_x_mg);
          check_field("accel_y_mg", want.accel_y_mg, got.accel_y_mg);
          check_field("accel_z_mg", want.accel_z_mg, got.accel_z_mg);
          check_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
        end
      end
      byte_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        parse_rx_byte(s_tdata);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // byte driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (rx_bytes_q.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= rx_bytes_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // report receiver stall pattern
  always @(negedge clk) begin
    rdy_cycle++;
    if (mode_left == 0) begin
      ready_mode = rdy_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: m_tready <= 1'b1;
      RDY_COIN: m_tready <= 1'($urandom_range(0, 1));
      RDY_EVERY4: m_tready <= (rdy_cycle % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(5, 30);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  initial begin
    int frame_bytes;
    logic [127:0] payload;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    byte_taken = 1'b0;
    err_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    mode_left = 0;
    stall_left = 0;
    rdy_cycle = 0;
    ready_mode = RDY_ALWAYS;
    rx_phase = imu_rvc_pkg::PH_HUNT1;
    rx_count = '0;
    rx_sum = '0;
    frame_bytes = 0;

    // noise outside a frame, then a bad second header byte
    rx_bytes_q.push_back(8'h00);
    rx_bytes_q.push_back(8'hFF);
    rx_bytes_q.push_back(imu_rvc_pkg::HDR_BYTE);
    rx_bytes_q.push_back(8'h55);
    // header byte as index and inside the payload, word extremes
    payload = {8'hFF, 8'h80, 8'h7F, 8'h00, 8'h01, 8'hAA, 8'hAA, 8'h00,
               8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h80, 8'h00, imu_rvc_pkg::HDR_BYTE};
    push_frame(payload, 1'b1);

    while (frame_bytes < RAND_FRAME_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          for (int i = 0; i < imu_rvc_pkg::PAYLOAD_LEN; i++) payload[8*i +: 8] = rand_byte();
          push_frame(payload, $urandom_range(0, 3) != 0);
          frame_bytes += imu_rvc_pkg::PAYLOAD_LEN + 3;
        end
        7: begin
          rx_bytes_q.push_back(imu_rvc_pkg::HDR_BYTE);
          rx_bytes_q.push_back(non_hdr_byte());
        end
        default: begin
          repeat ($urandom_range(1, 4)) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || s_tvalid || pending_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
